FILE: rtl/nrmc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA RMC parser package
// Shared types, character codes, field numbers and digit weighting helpers.
// ----------------------------------------------------------------------------
package nrmc_pkg;

    localparam logic [7:0] SEP_CHAR  = 8'h2c;
    localparam logic [7:0] ZERO_CHAR = 8'h30;
    localparam logic [7:0] NINE_CHAR = 8'h39;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_N    = 8'h4e;
    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_E    = 8'h45;
    localparam logic [7:0] CHAR_W    = 8'h57;

    localparam logic [3:0] COUNT_MAX = 4'd15;

    // Field numbers of the sentence, counted in commas.
    localparam logic [3:0] FLD_TIME    = 4'd1;
    localparam logic [3:0] FLD_STATUS  = 4'd2;
    localparam logic [3:0] FLD_LAT     = 4'd3;
    localparam logic [3:0] FLD_LAT_DIR = 4'd4;
    localparam logic [3:0] FLD_LON     = 4'd5;
    localparam logic [3:0] FLD_LON_DIR = 4'd6;
    localparam logic [3:0] FLD_DATE    = 4'd9;

    localparam logic [3:0] LAT_DIGITS = 4'd10;
    localparam logic [3:0] LON_DIGITS = 4'd11;
    localparam logic [3:0] PAIR_CHARS = 4'd6;

    localparam logic [4:0] HOUR_OFFSET_RESET = 5'd8;

    // One complete set of parsed values.
    typedef struct packed {
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic        fix_valid;
        logic [29:0] lat_scaled;
        logic        lat_south;
        logic [33:0] lon_scaled;
        logic        lon_west;
        logic [6:0]  day_of_month;
        logic [6:0]  month_num;
        logic [6:0]  year_two_digit;
    } fix_t;

    // A non-digit character is worth nothing.
    function automatic logic [3:0] digit_value(input logic [7:0] ch);
        logic [3:0] d;
        begin
            if (ch >= ZERO_CHAR && ch <= NINE_CHAR) begin
                d = 4'(ch - ZERO_CHAR);
            end else begin
                d = 4'd0;
            end
            return d;
        end
    endfunction

    // Adds a digit to a two-digit value: tens on even positions, units on odd.
    function automatic logic [6:0] pair_add(input logic [6:0] acc, input logic odd_pos,
                                            input logic [3:0] d);
        logic [6:0] term;
        begin
            term = odd_pos ? 7'(d) : 7'(d) * 7'd10;
            return acc + term;
        end
    endfunction

    // Latitude ddmm.mmmmm scaled by 100000; position 4 is the decimal point.
    function automatic logic [29:0] lat_term(input logic [3:0] pos, input logic [3:0] d);
        logic [29:0] t;
        begin
            unique case (pos)
                4'd0:    t = 30'(d) * 30'd100000000;
                4'd1:    t = 30'(d) * 30'd10000000;
                4'd2:    t = 30'(d) * 30'd1000000;
                4'd3:    t = 30'(d) * 30'd100000;
                4'd5:    t = 30'(d) * 30'd10000;
                4'd6:    t = 30'(d) * 30'd1000;
                4'd7:    t = 30'(d) * 30'd100;
                4'd8:    t = 30'(d) * 30'd10;
                4'd9:    t = 30'(d);
                default: t = '0;
            endcase
            return t;
        end
    endfunction

    // Longitude dddmm.mmmmm scaled by 100000; position 5 is the decimal point.
    function automatic logic [33:0] lon_term(input logic [3:0] pos, input logic [3:0] d);
        logic [33:0] t;
        begin
            unique case (pos)
                4'd0:    t = 34'(d) * 34'd1000000000;
                4'd1:    t = 34'(d) * 34'd100000000;
                4'd2:    t = 34'(d) * 34'd10000000;
                4'd3:    t = 34'(d) * 34'd1000000;
                4'd4:    t = 34'(d) * 34'd100000;
                4'd6:    t = 34'(d) * 34'd10000;
                4'd7:    t = 34'(d) * 34'd1000;
                4'd8:    t = 34'(d) * 34'd100;
                4'd9:    t = 34'(d) * 34'd10;
                4'd10:   t = 34'(d);
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

FILE: rtl/nrmc_parse_core.sv
// ----------------------------------------------------------------------------
// NMEA RMC parse core
// Field and character counters plus the parsed value registers, one byte a cycle while accept is high.
// ----------------------------------------------------------------------------
module nrmc_parse_core
    import nrmc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    input  logic       end_of_sentence,
    output fix_t       parsed_next
);

    logic [3:0] field_reg, field_next;
    logic [3:0] pos_reg, pos_next;
    fix_t       vals_reg, vals_next;
    logic [3:0] digit;

    assign digit = digit_value(rx_byte);

    always_comb begin
        field_next = field_reg;
        pos_next   = pos_reg;
        vals_next  = vals_reg;
        if (accept) begin
            if (rx_byte == SEP_CHAR) begin
                // An empty hemisphere field clears its direction.
                if (pos_reg == 4'd0) begin
                    if (field_reg == FLD_LAT_DIR) begin
                        vals_next.lat_south = 1'b0;
                    end
                    if (field_reg == FLD_LON_DIR) begin
                        vals_next.lon_west = 1'b0;
                    end
                end
                if (field_reg != COUNT_MAX) begin
                    field_next = field_reg + 4'd1;
                end
                pos_next = 4'd0;
                unique case (field_next)
                    FLD_TIME: begin
                        vals_next.hour   = '0;
                        vals_next.minute = '0;
                        vals_next.second = '0;
                    end
                    FLD_STATUS: vals_next.fix_valid  = 1'b0;
                    FLD_LAT:    vals_next.lat_scaled = '0;
                    FLD_LON:    vals_next.lon_scaled = '0;
                    FLD_DATE: begin
                        vals_next.day_of_month   = '0;
                        vals_next.month_num      = '0;
                        vals_next.year_two_digit = '0;
                    end
                    default: ;
                endcase
            end else begin
                unique case (field_reg)
                    FLD_TIME: begin
                        if (pos_reg < PAIR_CHARS) begin
                            unique case (pos_reg[2:1])
                                2'd0: vals_next.hour =
                                    pair_add(vals_reg.hour, pos_reg[0], digit);
                                2'd1: vals_next.minute =
                                    pair_add(vals_reg.minute, pos_reg[0], digit);
                                default: vals_next.second =
                                    pair_add(vals_reg.second, pos_reg[0], digit);
                            endcase
                        end
                    end
                    FLD_STATUS: begin
                        if (pos_reg == 4'd0) begin
                            vals_next.fix_valid = (rx_byte == CHAR_A);
                        end
                    end
                    FLD_LAT: begin
                        if (pos_reg < LAT_DIGITS) begin
                            vals_next.lat_scaled = vals_reg.lat_scaled
                                                 + lat_term(pos_reg, digit);
                        end
                    end
                    FLD_LAT_DIR: begin
                        if (pos_reg == 4'd0) begin
                            if (rx_byte == CHAR_N) begin
                                vals_next.lat_south = 1'b0;
                            end else if (rx_byte == CHAR_S) begin
                                vals_next.lat_south = 1'b1;
                            end
                        end
                    end
                    FLD_LON: begin
                        if (pos_reg < LON_DIGITS) begin
                            vals_next.lon_scaled = vals_reg.lon_scaled
                                                 + lon_term(pos_reg, digit);
                        end
                    end
                    FLD_LON_DIR: begin
                        if (pos_reg == 4'd0) begin
                            if (rx_byte == CHAR_E) begin
                                vals_next.lon_west = 1'b0;
                            end else if (rx_byte == CHAR_W) begin
                                vals_next.lon_west = 1'b1;
                            end
                        end
                    end
                    FLD_DATE: begin
                        if (pos_reg < PAIR_CHARS) begin
                            unique case (pos_reg[2:1])
                                2'd0: vals_next.day_of_month =
                                    pair_add(vals_reg.day_of_month, pos_reg[0], digit);
                                2'd1: vals_next.month_num =
                                    pair_add(vals_reg.month_num, pos_reg[0], digit);
                                default: vals_next.year_two_digit =
                                    pair_add(vals_reg.year_two_digit, pos_reg[0], digit);
                            endcase
                        end
                    end
                    default: ;
                endcase
                if (pos_reg != COUNT_MAX) begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            // The last byte is parsed first, then both counters restart.
            if (end_of_sentence) begin
                field_next = 4'd0;
                pos_next   = 4'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_reg <= 4'd0;
            pos_reg   <= 4'd0;
            vals_reg  <= '0;
        end else begin
            field_reg <= field_next;
            pos_reg   <= pos_next;
            vals_reg  <= vals_next;
        end
    end

    assign parsed_next = vals_next;

    a_eos_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && end_of_sentence |=> field_reg == 4'd0 && pos_reg == 4'd0)
        else $error("counters not restarted after last byte");

    a_sep_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && rx_byte == SEP_CHAR |=> pos_reg == 4'd0)
        else $error("character position not cleared by separator");

    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !end_of_sentence && rx_byte != SEP_CHAR && pos_reg != COUNT_MAX
        |=> pos_reg == $past(pos_reg) + 4'd1)
        else $error("character position did not advance");

endmodule

FILE: rtl/nrmc_result_stage.sv
// ----------------------------------------------------------------------------
// NMEA RMC result stage
// Hour offset register, local hour adjustment and the registered result item.
// ----------------------------------------------------------------------------
module nrmc_result_stage
    import nrmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  fix_t        parsed,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        m_ready,
    output logic        m_valid,
    output fix_t        result
);

    logic [4:0] hour_offset_reg;
    logic       m_valid_reg, m_valid_next;
    fix_t       result_reg, result_next;
    logic [7:0] hour_sum;

    assign hour_sum = 8'(parsed.hour) + 8'(hour_offset_reg);

    always_comb begin
        result_next      = parsed;
        result_next.hour = hour_sum[7] ? 7'h7f : hour_sum[6:0];
        m_valid_next     = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hour_offset_reg <= HOUR_OFFSET_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                hour_offset_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign result  = result_reg;

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> !m_valid_reg || m_ready)
        else $error("result item overwritten before it was taken");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid_reg)
        else $error("loaded result item not presented");

    a_hour_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        load && !cfg_wr_en |=> result_reg.hour >= 7'(hour_offset_reg))
        else $error("local hour below the configured offset");

endmodule

FILE: rtl/nmea_rmc_sentence_parser_unit.sv
// A result item appears in the cycle after its flagged last byte is accepted.
// Throughput: one byte per cycle unless a flagged last byte waits for room; all fields update in one pass.
// A byte without the end flag is accepted even while a result item waits to be taken.
// Reset (aresetn low, synchronous) clears counters and values; the hour offset becomes 8.
// ----------------------------------------------------------------------------
// NMEA RMC sentence parser unit
// Parses an RMC sentence byte by byte and presents time, fix status, position
// and date as one result item when the last byte of the sentence arrives.
// ----------------------------------------------------------------------------
module nmea_rmc_sentence_parser_unit
    import nrmc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration: hour offset added to the parsed UTC hour.
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,

    // Input channel: one sentence character per item.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_end_of_sentence,

    // Result channel: one item per sentence.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_hour,
    output logic [6:0]  m_minute,
    output logic [6:0]  m_second,
    output logic        m_fix_valid,
    output logic [29:0] m_lat_scaled,
    output logic        m_lat_south,
    output logic [33:0] m_lon_scaled,
    output logic        m_lon_west,
    output logic [6:0]  m_day_of_month,
    output logic [6:0]  m_month_num,
    output logic [6:0]  m_year_two_digit
);

    logic accept;
    logic load;
    fix_t parsed_next;
    fix_t result;

    // Only the last byte of a sentence needs room in the result register, so
    // every other byte flows in regardless of the downstream side. The flagged
    // byte is taken when the register is empty or is being emptied this cycle.
    assign s_ready = !s_end_of_sentence || !m_valid || m_ready;
    assign accept  = s_valid && s_ready;
    assign load    = accept && s_end_of_sentence;

    // The parse core keeps the field counter, the character position and the
    // running values; it offers the values as they stand after this byte.
    nrmc_parse_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .rx_byte         (s_rx_byte),
        .end_of_sentence (s_end_of_sentence),
        .parsed_next     (parsed_next)
    );

    // The result stage adds the local hour offset, saturating at the top of
    // the seven-bit range, and holds the item until the consumer takes it.
    nrmc_result_stage u_result (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (load),
        .parsed      (parsed_next),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .result      (result)
    );

    assign m_hour           = result.hour;
    assign m_minute         = result.minute;
    assign m_second         = result.second;
    assign m_fix_valid      = result.fix_valid;
    assign m_lat_scaled     = result.lat_scaled;
    assign m_lat_south      = result.lat_south;
    assign m_lon_scaled     = result.lon_scaled;
    assign m_lon_west       = result.lon_west;
    assign m_day_of_month   = result.day_of_month;
    assign m_month_num      = result.month_num;
    assign m_year_two_digit = result.year_two_digit;

endmodule
